// File: src/assert_macros.svh
// Assertion helpers used by the bound checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define RVM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/rvm_pkg.sv
package rvm_pkg;

   localparam int SAMPLE_DEPTH_DEFAULT = 65536;

   localparam int SAMPLE_W = 16;
   localparam int POS_W    = 17;
   localparam int RATE_W   = 18;
   localparam int SCALE_W  = 16;
   localparam int VOL_W    = 8;
   localparam int CHAN_W   = 2;
   localparam int PROD_W   = RATE_W + SCALE_W;
   localparam int INC_W    = PROD_W - 8 + 1;
   localparam int DVD_W    = INC_W + 1;
   localparam int DIV_STEPS = DVD_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_ADDR_W-1:0] CSR_VOLUME        = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RATE_SCALE    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SOURCE_RATE   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUTPUT_RATE   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHANNEL_COUNT = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_BUFFER_LENGTH = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOOP_MODE     = 3'd6;

   localparam logic [VOL_W-1:0]   VOLUME_RESET        = 8'd128;
   localparam logic [SCALE_W-1:0] RATE_SCALE_RESET    = 16'd256;
   localparam logic [RATE_W-1:0]  SOURCE_RATE_RESET   = 18'd48000;
   localparam logic [RATE_W-1:0]  OUTPUT_RATE_RESET   = 18'd48000;
   localparam logic [CHAN_W-1:0]  CHANNEL_COUNT_RESET = 2'd2;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_MIX     = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   typedef struct packed {
      logic [1:0]                 op;
      logic [15:0]                sample_address;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic signed [SAMPLE_W-1:0] mix_left;
      logic signed [SAMPLE_W-1:0] mix_right;
   } rvm_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_left;
      logic signed [SAMPLE_W-1:0] out_right;
      logic                       ended;
   } rvm_rsp_type;

   typedef struct packed {
      logic write_sample;
      logic restart;
      logic capture_mix;
      logic end_frame;
      logic read_left;
      logic read_right;
      logic div_init;
      logic div_step;
      logic update;
      logic load_rsp;
   } rvm_cmd_type;

   typedef struct packed {
      logic past_end;
      logic rsp_free;
   } rvm_status_type;

endpackage

// File: src/rvm_ram.sv
module rvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/rvm_ctrl.sv
module rvm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_op,
   output logic                   req_stall,
   input  rvm_pkg::rvm_status_type status,
   output rvm_pkg::rvm_cmd_type    cmd
);

   import rvm_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_LEFT   = 3'd2;
   localparam logic [2:0] ST_RIGHT  = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_UPDATE = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_LOAD:    cmd.write_sample = 1'b1;
                  OP_RESTART: cmd.restart = 1'b1;
                  OP_MIX: begin
                     cmd.capture_mix = 1'b1;
                     state_in        = ST_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            if (status.past_end) begin
               cmd.end_frame = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.read_left = 1'b1;
               state_in      = ST_LEFT;
            end
         end
         ST_LEFT: begin
            cmd.read_right = 1'b1;
            state_in       = ST_RIGHT;
         end
         ST_RIGHT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: src/rvm_datapath.sv
module rvm_datapath #(
   parameter int SAMPLE_DEPTH = rvm_pkg::SAMPLE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rvm_pkg::rvm_req_type                req_data,
   input  rvm_pkg::rvm_cmd_type                cmd,
   output rvm_pkg::rvm_status_type             status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rvm_pkg::rvm_rsp_type                rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rvm_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [rvm_pkg::CSR_DATA_W-1:0]      csr_data
);

   import rvm_pkg::*;

   localparam int ADDR_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
   localparam logic signed [SAMPLE_W+2:0] SAT_HI = 19'sd32767;
   localparam logic signed [SAMPLE_W+2:0] SAT_LO = -19'sd32768;

   // Configuration registers.
   logic [VOL_W-1:0]   volume_ff;
   logic [SCALE_W-1:0] rate_scale_ff;
   logic [RATE_W-1:0]  source_rate_ff;
   logic [RATE_W-1:0]  output_rate_ff;
   logic [CHAN_W-1:0]  channel_count_ff;
   logic [POS_W-1:0]   buffer_length_ff;
   logic               loop_mode_ff;

   // Voice state.
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [RATE_W-1:0] phase_ff, phase_in;

   // Per-frame working registers.
   logic signed [SAMPLE_W-1:0] mix_left_ff, mix_right_ff;
   logic signed [SAMPLE_W-1:0] out_left_ff, out_right_ff;
   logic                       ended_ff;
   logic                       rd_oob_ff;
   logic [PROD_W-1:0]          prod_rate_ff;
   logic [INC_W-1:0]           inc_ff;
   logic [DVD_W-1:0]           dvd_ff;
   logic [DVD_W-1:0]           quo_ff;
   logic [RATE_W-1:0]          rem_ff;
   logic                       big_ff;

   logic                rsp_valid_ff;
   rvm_rsp_type         rsp_data_ff;

   // Store access.
   logic [31:0]         wr_ext, rd_ext;
   logic [RATE_W-1:0]   right_idx;
   logic [RATE_W-1:0]   rd_idx;
   logic                wr_en;
   logic [SAMPLE_W-1:0] rd_data;

   // Sample scaling.
   logic signed [SAMPLE_W-1:0]   smp;
   logic signed [SAMPLE_W+8:0]   prod;
   logic signed [SAMPLE_W+1:0]   scaled;
   logic signed [SAMPLE_W-1:0]   mix_sel;
   logic signed [SAMPLE_W+2:0]   sum;
   logic signed [SAMPLE_W-1:0]   sat_val;

   // Phase divider and update.
   logic [RATE_W-1:0] rate_eff;
   logic [RATE_W:0]   r1, m1, r2, m2;
   logic              ge1, ge2;
   logic [DVD_W:0]    step;
   logic [DVD_W:0]    pos_sum;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff        <= VOLUME_RESET;
         rate_scale_ff    <= RATE_SCALE_RESET;
         source_rate_ff   <= SOURCE_RATE_RESET;
         output_rate_ff   <= OUTPUT_RATE_RESET;
         channel_count_ff <= CHANNEL_COUNT_RESET;
         buffer_length_ff <= '0;
         loop_mode_ff     <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_VOLUME:        volume_ff        <= csr_data[VOL_W-1:0];
            CSR_RATE_SCALE:    rate_scale_ff    <= csr_data[SCALE_W-1:0];
            CSR_SOURCE_RATE:   source_rate_ff   <= csr_data[RATE_W-1:0];
            CSR_OUTPUT_RATE:   output_rate_ff   <= csr_data[RATE_W-1:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[CHAN_W-1:0];
            CSR_BUFFER_LENGTH: buffer_length_ff <= csr_data[POS_W-1:0];
            CSR_LOOP_MODE:     loop_mode_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Channel counts of 0 and 3 fold onto mono and stereo; bit 1 alone decides.
   assign right_idx = {1'b0, pos_ff} + RATE_W'(channel_count_ff[1]);
   assign rd_idx    = cmd.read_right ? right_idx : {1'b0, pos_ff};
   assign rd_ext    = 32'(rd_idx);
   assign wr_ext    = 32'(req_data.sample_address);
   assign wr_en     = cmd.write_sample && (wr_ext < 32'(SAMPLE_DEPTH));

   rvm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (SAMPLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ext[ADDR_W-1:0]),
      .wr_data (req_data.sample_value),
      .rd_addr (rd_ext[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // One scaler serves both channels: left in the cycle after the left read,
   // right in the cycle after the right read.
   assign smp     = rd_oob_ff ? '0 : $signed(rd_data);
   assign prod    = smp * $signed({1'b0, volume_ff});
   assign scaled  = prod[SAMPLE_W+8:7];
   assign mix_sel = cmd.read_right ? mix_left_ff : mix_right_ff;
   assign sum     = (SAMPLE_W+3)'(mix_sel) + (SAMPLE_W+3)'(scaled);

   always_comb begin
      priority if (sum > SAT_HI) begin
         sat_val = SAT_HI[SAMPLE_W-1:0];
      end else if (sum < SAT_LO) begin
         sat_val = SAT_LO[SAMPLE_W-1:0];
      end else begin
         sat_val = sum[SAMPLE_W-1:0];
      end
   end

   assign rate_eff = (output_rate_ff == '0) ? RATE_W'(1) : output_rate_ff;

   // Two restoring division steps per cycle.
   assign r1  = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge1 = (r1 >= {1'b0, rate_eff});
   assign m1  = ge1 ? (r1 - {1'b0, rate_eff}) : r1;
   assign r2  = {m1[RATE_W-1:0], dvd_ff[DVD_W-2]};
   assign ge2 = (r2 >= {1'b0, rate_eff});
   assign m2  = ge2 ? (r2 - {1'b0, rate_eff}) : r2;

   assign step    = channel_count_ff[1] ? {quo_ff, 1'b0} : {1'b0, quo_ff};
   assign pos_sum = (DVD_W+1)'(pos_ff) + step;

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      if (big_ff) begin
         pos_in   = (pos_sum > (DVD_W+1)'(POS_MAX)) ? POS_MAX : pos_sum[POS_W-1:0];
         phase_in = rem_ff + 1'b1;
      end else begin
         phase_in = inc_ff[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= '0;
      end else if (cmd.restart || (cmd.end_frame && loop_mode_ff)) begin
         pos_ff   <= '0;
         phase_ff <= '0;
      end else if (cmd.update) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_oob_ff <= !(rd_ext < 32'(SAMPLE_DEPTH));
      if (cmd.capture_mix) begin
         mix_left_ff  <= req_data.mix_left;
         mix_right_ff <= req_data.mix_right;
      end
      if (cmd.end_frame) begin
         out_left_ff  <= mix_left_ff;
         out_right_ff <= mix_right_ff;
         ended_ff     <= 1'b1;
      end
      if (cmd.read_left) begin
         prod_rate_ff <= source_rate_ff * rate_scale_ff;
      end
      if (cmd.read_right) begin
         out_left_ff <= sat_val;
         ended_ff    <= 1'b0;
         inc_ff      <= INC_W'(prod_rate_ff[PROD_W-1:8]) + INC_W'(phase_ff);
      end
      if (cmd.div_init) begin
         out_right_ff <= sat_val;
         dvd_ff       <= DVD_W'(inc_ff) - 1'b1;
         quo_ff       <= '0;
         rem_ff       <= '0;
         big_ff       <= (inc_ff > INC_W'(rate_eff));
      end
      if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[DVD_W-3:0], 2'b00};
         quo_ff <= {quo_ff[DVD_W-3:0], ge1, ge2};
         rem_ff <= m2[RATE_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= '{out_left: out_left_ff, out_right: out_right_ff, ended: ended_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.past_end = (pos_ff >= buffer_length_ff);
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/resampling_voice_mixer.sv
// One playback voice of a nearest-neighbor resampling mixer. A load transaction
// writes one signed 16-bit sample into the sample store and a restart transaction
// rewinds the voice; both return nothing and leave the voice idle, so the next
// request is taken in the following cycle. A mix transaction adds the scaled
// voice sample to one stereo frame of the existing mix and returns exactly one
// result. It keeps the request side stalled until its result is loaded into the
// output register, so the voice takes no new request while a frame is in
// progress. A check state tests the end of the buffer, starts the left read of
// the single-read-port store and forms the rate product. The left and right
// states then scale the left and right samples. A divide state runs a
// two-bit-per-cycle divider that works out how many source samples the phase
// accumulator steps over. An update state moves the position and phase, and a
// done state loads the result register once the output register is free. A
// frame past the end of the buffer skips the read, scale, divide and update
// states and returns unchanged with ended set. The result sits in an output
// register, so the next transaction is taken while an earlier result still waits
// to be collected. The sample store has no reset and no clearing pass; reading an
// entry that was never loaded returns an undefined value. Configuration registers
// may be written at any time the voice is idle and csr_ready is always high.
module resampling_voice_mixer #(
   parameter int SAMPLE_DEPTH = rvm_pkg::SAMPLE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rvm_pkg::rvm_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rvm_pkg::rvm_rsp_type           rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rvm_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [rvm_pkg::CSR_DATA_W-1:0] csr_data
);

   import rvm_pkg::*;

   // Commands from the sequencer and status back from the datapath.
   rvm_cmd_type    cmd;
   rvm_status_type status;

   // The sequencer owns the request handshake and walks each mix transaction
   // through its read, scale, divide and update steps.
   rvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the configuration registers, the sample store, the
   // voice position and phase, the divider and the result register.
   rvm_datapath #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

// File: src/rvm_checker.sv
`include "assert_macros.svh"

module rvm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input rvm_pkg::rvm_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall
);

   import rvm_pkg::*;

   logic req_take;

   assign req_take = req_valid && !req_stall;

   `RVM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

   `RVM_ASSERT_NEXT(a_mix_busy, clock, reset, req_take && (req_data.op == OP_MIX), req_stall, "mix transaction did not occupy the voice")

   `RVM_ASSERT_NEXT(a_other_free, clock, reset, req_take && (req_data.op != OP_MIX), !req_stall, "load or restart stalled the next request")

   `RVM_ASSERT(a_rsp_after_mix, clock, reset, $rose(rsp_valid) |-> ($past(req_stall) && !req_stall), "result appeared outside a mix transaction")

endmodule

bind resampling_voice_mixer rvm_checker u_checker (.*);

// File: verif/resampling_voice_mixer_checker.sv
module resampling_voice_mixer_checker #(
   parameter int SAMPLE_DEPTH = rvm_pkg::SAMPLE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  rvm_pkg::rvm_req_type           req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  rvm_pkg::rvm_rsp_type           rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [rvm_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [rvm_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             fail_count,
   output int                             pending_frames
);
   timeunit 1ns;
   timeprecision 1ps;
   import rvm_pkg::*;

   localparam int MIX_MAX = 32767;
   localparam int MIX_MIN = -32768;

   // Voice state and register copies.
   logic signed [SAMPLE_W-1:0] sample_mem [0:SAMPLE_DEPTH-1];
   logic [POS_W-1:0]           play_pos;
   logic [31:0]                phase_acc;
   logic [VOL_W-1:0]           gain;
   logic [SCALE_W-1:0]         speed;
   logic [RATE_W-1:0]          src_hz;
   logic [RATE_W-1:0]          out_hz;
   logic [CHAN_W-1:0]          chans;
   logic [POS_W-1:0]           buf_len;
   logic                       looping;

   rvm_rsp_type frame_queue [$];

   // Entries that were never loaded are never read by the stimulus; zero keeps them defined.
   initial begin
      for (int i = 0; i < SAMPLE_DEPTH; i++) begin
         sample_mem[i] = '0;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] fetch(input logic [63:0] idx);
      if (idx >= 64'(SAMPLE_DEPTH)) begin
         return '0;
      end
      return sample_mem[idx];
   endfunction

   // Floor of sample times gain over 128.
   function automatic int scaled(input logic signed [SAMPLE_W-1:0] smp);
      int prod;
      prod = int'(smp) * int'(gain);
      return prod >>> 7;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] clamp16(input int v);
      if (v > MIX_MAX) begin
         return SAMPLE_W'(MIX_MAX);
      end
      if (v < MIX_MIN) begin
         return SAMPLE_W'(MIX_MIN);
      end
      return SAMPLE_W'(v);
   endfunction

   // Works out one mixed frame and moves the voice on.
   function automatic rvm_rsp_type mix_frame(input rvm_req_type r);
      rvm_rsp_type res;
      logic [63:0] stride;
      logic [63:0] divisor;
      logic [63:0] acc;
      logic [63:0] skips;
      logic [63:0] new_pos;
      if (play_pos >= buf_len) begin
         res.out_left  = r.mix_left;
         res.out_right = r.mix_right;
         res.ended     = 1'b1;
         if (looping) begin
            play_pos  = '0;
            phase_acc = '0;
         end
         return res;
      end
      stride  = (chans == 2'd0) ? 64'd1 : ((chans == 2'd3) ? 64'd2 : 64'(chans));
      divisor = (out_hz == '0) ? 64'd1 : 64'(out_hz);
      res.out_left  = clamp16(int'($signed(r.mix_left)) + scaled(fetch(64'(play_pos))));
      res.out_right = clamp16(int'($signed(r.mix_right))
                              + scaled(fetch(64'(play_pos) + stride - 64'd1)));
      res.ended     = 1'b0;
      acc   = ((64'(src_hz) * 64'(speed)) >> 8) + 64'(phase_acc);
      skips = (acc > divisor) ? (acc - 64'd1) / divisor : 64'd0;
      phase_acc = 32'(acc - skips * divisor);
      new_pos   = 64'(play_pos) + skips * stride;
      play_pos  = (new_pos > 64'(POS_MAX)) ? POS_MAX : new_pos[POS_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rvm_rsp_type want;
      if (reset) begin
         play_pos   = '0;
         phase_acc  = '0;
         gain       = VOLUME_RESET;
         speed      = RATE_SCALE_RESET;
         src_hz     = SOURCE_RATE_RESET;
         out_hz     = OUTPUT_RATE_RESET;
         chans      = CHANNEL_COUNT_RESET;
         buf_len    = '0;
         looping    = 1'b0;
         fail_count = 0;
         frame_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VOLUME:        gain    = csr_data[VOL_W-1:0];
               CSR_RATE_SCALE:    speed   = csr_data[SCALE_W-1:0];
               CSR_SOURCE_RATE:   src_hz  = csr_data[RATE_W-1:0];
               CSR_OUTPUT_RATE:   out_hz  = csr_data[RATE_W-1:0];
               CSR_CHANNEL_COUNT: chans   = csr_data[CHAN_W-1:0];
               CSR_BUFFER_LENGTH: buf_len = csr_data[POS_W-1:0];
               CSR_LOOP_MODE:     looping = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_data.op)
               OP_LOAD: begin
                  if (32'(req_data.sample_address) < SAMPLE_DEPTH) begin
                     sample_mem[req_data.sample_address] = req_data.sample_value;
                  end
               end
               OP_RESTART: begin
                  play_pos  = '0;
                  phase_acc = '0;
               end
               OP_MIX: frame_queue.push_back(mix_frame(req_data));
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (frame_queue.size() == 0) begin
               $error("unexpected result transaction: out_left %0d out_right %0d ended %0d",
                      rsp_data.out_left, rsp_data.out_right, rsp_data.ended);
               fail_count++;
            end else begin
               want = frame_queue.pop_front();
               if (rsp_data.out_left !== want.out_left) begin
                  $error("out_left mismatch: expected %0d, actual %0d",
                         want.out_left, rsp_data.out_left);
                  fail_count++;
               end
               if (rsp_data.out_right !== want.out_right) begin
                  $error("out_right mismatch: expected %0d, actual %0d",
                         want.out_right, rsp_data.out_right);
                  fail_count++;
               end
               if (rsp_data.ended !== want.ended) begin
                  $error("ended mismatch: expected %0d, actual %0d",
                         want.ended, rsp_data.ended);
                  fail_count++;
               end
            end
         end
      end
      pending_frames = frame_queue.size();
   end

endmodule

// File: verif/resampling_voice_mixer_tb.sv
module resampling_voice_mixer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rvm_pkg::*;

   localparam int STORE_DEPTH = SAMPLE_DEPTH_DEFAULT;

   // Number of counted request transactions in the random part.
   localparam int ITEM_TARGET = 1450;

   // Largest buffer length used in the random part. Entries 0 up to this index are
   // loaded before any random frame plays.
   localparam int PLAY_SPAN = 64;

   // Idle time after the last expected frame has been collected. Waiting it out makes
   // sure that a trailing load or restart has also finished before a register is
   // touched.
   localparam int SETTLE_CYCLES = 40;

   // Long receiver hold-off used to fill the block and back up the request side.
   localparam int HOLD_CYCLES = 400;

   // Slowest correct run: about 1700 transactions, each of which may cost an idle gap,
   // its time in the block and a receiver stall, plus the settle pauses between phases
   // and the long hold-offs. The limit below lies well above that.
   localparam int CYCLE_LIMIT = 500_000;

   // The fourth encoding of the op field has no function.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [VOL_W-1:0]   volume;
      logic [SCALE_W-1:0] rate_scale;
      logic [RATE_W-1:0]  source_rate;
      logic [RATE_W-1:0]  output_rate;
      logic [CHAN_W-1:0]  channel_count;
      logic [POS_W-1:0]   buffer_length;
      logic               loop_mode;
   } voice_setting_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   rvm_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b1;
   rvm_rsp_type           rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int   fail_count;
   int   pending_frames;
   int   cycle_count = 0;
   int   rsp_wait = 0;
   logic rsp_calm = 1'b0;
   logic hold_rsp = 1'b0;
   logic pressure_go = 1'b0;
   logic req_calm = 1'b0;

   resampling_voice_mixer #(
      .SAMPLE_DEPTH(STORE_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   // The checker watches all three channels, predicts every frame and compares.
   resampling_voice_mixer_checker #(
      .SAMPLE_DEPTH(STORE_DEPTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_frames(pending_frames)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog. A hung handshake or a frame that never comes back ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("resampling_voice_mixer_tb failed");
         $finish;
      end
   end

   // Idle cycles before a transaction. In a calm stretch there is no idling at all,
   // otherwise about a third of the draws are still zero so back-to-back traffic occurs.
   function automatic int draw_gap(input logic calm);
      if (calm || $urandom_range(0, 2) == 0) begin
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   // Mix values lean on the limits so that saturation in both directions shows up.
   function automatic logic [15:0] rand_level();
      case ($urandom_range(0, 11))
         0:       return 16'h7fff;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // Fields that the op does not use are filled with noise; the block must ignore them.
   function automatic rvm_req_type mk_item(input logic [1:0] op);
      rvm_req_type item;
      item                = rvm_req_type'({$urandom, $urandom, $urandom});
      item.op             = op;
      return item;
   endfunction

   function automatic rvm_req_type mk_load(input logic [15:0] addr, input logic [15:0] value);
      rvm_req_type item;
      item                = mk_item(OP_LOAD);
      item.sample_address = addr;
      item.sample_value   = value;
      return item;
   endfunction

   function automatic rvm_req_type mk_mix(input logic [15:0] left, input logic [15:0] right);
      rvm_req_type item;
      item           = mk_item(OP_MIX);
      item.mix_left  = left;
      item.mix_right = right;
      return item;
   endfunction

   function automatic voice_setting_type mk_setting(
      input logic [VOL_W-1:0]   volume,
      input logic [SCALE_W-1:0] rate_scale,
      input logic [RATE_W-1:0]  source_rate,
      input logic [RATE_W-1:0]  output_rate,
      input logic [CHAN_W-1:0]  channel_count,
      input logic [POS_W-1:0]   buffer_length,
      input logic               loop_mode
   );
      voice_setting_type s;
      s.volume        = volume;
      s.rate_scale    = rate_scale;
      s.source_rate   = source_rate;
      s.output_rate   = output_rate;
      s.channel_count = channel_count;
      s.buffer_length = buffer_length;
      s.loop_mode     = loop_mode;
      return s;
   endfunction

   // Random voice setting. Extremes come up often; the buffer stays within the loaded
   // span, so the end of the buffer, the ended flag and looping are reached many times
   // and every sample the voice reads has been loaded.
   function automatic voice_setting_type random_setting();
      voice_setting_type s;
      case ($urandom_range(0, 3))
         0:       s.volume = '0;
         1:       s.volume = '1;
         default: s.volume = VOL_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0:       s.rate_scale = '0;
         1:       s.rate_scale = '1;
         2:       s.rate_scale = RATE_SCALE_RESET;
         3, 4:    s.rate_scale = SCALE_W'($urandom_range(0, 1023));
         default: s.rate_scale = SCALE_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0:       s.source_rate = RATE_W'(1);
         1:       s.source_rate = RATE_W'(192000);
         2:       s.source_rate = '1;
         default: s.source_rate = RATE_W'($urandom_range(1, 192000));
      endcase
      case ($urandom_range(0, 5))
         0:       s.output_rate = '0;
         1:       s.output_rate = RATE_W'(1);
         2:       s.output_rate = RATE_W'(192000);
         3:       s.output_rate = '1;
         default: s.output_rate = RATE_W'($urandom_range(1, 192000));
      endcase
      // Mostly mono or stereo; the two odd encodings now and then.
      case ($urandom_range(0, 7))
         0:       s.channel_count = 2'd0;
         1:       s.channel_count = 2'd3;
         2, 3, 4: s.channel_count = 2'd1;
         default: s.channel_count = 2'd2;
      endcase
      case ($urandom_range(0, 9))
         0:       s.buffer_length = '0;
         1, 2:    s.buffer_length = POS_W'(PLAY_SPAN);
         default: s.buffer_length = POS_W'($urandom_range(1, PLAY_SPAN));
      endcase
      s.loop_mode = 1'($urandom_range(0, 1));
      return s;
   endfunction

   // Offers one request transaction after the given number of idle cycles and returns
   // in the time step of the edge that accepted it. A zero gap keeps valid high, so
   // valid is never dropped and raised again within one step.
   task automatic send(input rvm_req_type item, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stops offering requests and waits until every predicted frame has been collected,
   // then lets the block finish any load or restart that is still in flight.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_frames != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write. Valid stays high for a following write; write_setting() lowers it.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Writes the whole register set. Called only while the voice is idle.
   task automatic write_setting(input voice_setting_type s);
      write_reg(CSR_VOLUME,        CSR_DATA_W'(s.volume));
      write_reg(CSR_RATE_SCALE,    CSR_DATA_W'(s.rate_scale));
      write_reg(CSR_SOURCE_RATE,   CSR_DATA_W'(s.source_rate));
      write_reg(CSR_OUTPUT_RATE,   CSR_DATA_W'(s.output_rate));
      write_reg(CSR_CHANNEL_COUNT, CSR_DATA_W'(s.channel_count));
      write_reg(CSR_BUFFER_LENGTH, CSR_DATA_W'(s.buffer_length));
      write_reg(CSR_LOOP_MODE,     CSR_DATA_W'(s.loop_mode));
      csr_valid <= 1'b0;
   endtask

   // Result side. After each collected frame the receiver draws how long it stalls.
   // The calm flag flips now and then, giving stretches where every frame is taken at
   // once. While the pressure process holds, stall stays high regardless.
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_stall <= 1'b1;
         rsp_wait  <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if ($urandom_range(0, 63) == 0) begin
            rsp_calm <= ~rsp_calm;
         end
         w = draw_gap(rsp_calm);
         rsp_wait  <= w;
         rsp_stall <= hold_rsp || (w != 0);
      end else if (rsp_wait > 1) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_wait  <= 0;
         rsp_stall <= hold_rsp;
      end
   end

   // Back pressure. A few times during the random part, and only while the sender is
   // offering a transaction, the receiver stops collecting for a long stretch. The
   // output register and the frame in progress fill up, and the block has to stall
   // its request side while the sender keeps offering.
   initial begin
      wait (pressure_go);
      repeat (3) begin
         repeat ($urandom_range(300, 3000)) @(posedge clock);
         while (!req_valid) @(posedge clock);
         hold_rsp <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_rsp <= 1'b0;
      end
   end

   initial begin
      int          issued;
      int          burst;
      int          pick;
      rvm_req_type item;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Registers still hold their reset values, so the buffer length is zero: the
      // first frame is already past the end and must come back unchanged with ended
      // set. The unused op must be ignored, and a restart returns nothing.
      send(mk_mix(16'h7fff, 16'h8000), draw_gap(1'b0));
      send(mk_item(OP_UNUSED), draw_gap(1'b0));
      send(mk_item(OP_RESTART), draw_gap(1'b0));

      // Load every entry that a random setting lets the voice read: positions below the
      // largest buffer length, plus one more for the right channel. The directed cases
      // below load what they read before they read it.
      for (int a = 0; a <= PLAY_SPAN; a++) begin
         send(mk_load(16'(a), 16'($urandom)), draw_gap(1'b0));
      end
      settle();

      // Full gain, unity rate, stereo, three samples. Extreme samples against extreme
      // mix values saturate both ways; the later frames run off the end without loop.
      write_setting(mk_setting('1, RATE_SCALE_RESET, RATE_W'(48000), RATE_W'(48000),
                               2'd2, POS_W'(3), 1'b0));
      send(mk_load(16'd0, 16'h7fff), draw_gap(1'b0));
      send(mk_load(16'd1, 16'h8000), draw_gap(1'b0));
      send(mk_load(16'd2, 16'hffff), draw_gap(1'b0));
      send(mk_load(16'd3, 16'h0001), draw_gap(1'b0));
      send(mk_mix(16'h7fff, 16'h8000), draw_gap(1'b0));
      repeat (4) send(mk_mix(rand_level(), rand_level()), draw_gap(1'b0));
      send(mk_item(OP_RESTART), draw_gap(1'b0));
      send(mk_mix(16'h8000, 16'h7fff), draw_gap(1'b0));
      settle();

      // Zero gain, largest rate product, zero output rate (acts as one), channel count
      // three (acts as two) and the largest buffer length. The first frame throws the
      // position to its saturation point; the next one finds the saturated position
      // equal to the buffer length, so it passes unchanged with ended set.
      write_setting(mk_setting('0, '1, '1, '0, 2'd3, '1, 1'b0));
      send(mk_mix(rand_level(), rand_level()), draw_gap(1'b0));
      send(mk_mix(rand_level(), rand_level()), draw_gap(1'b0));
      settle();

      // Same position, now past the end with loop on: the frame passes unchanged and
      // the voice rewinds, so the next frame plays from the start again.
      write_setting(mk_setting(VOLUME_RESET, '1, '1, '0, 2'd3, POS_W'(STORE_DEPTH), 1'b1));
      send(mk_mix(rand_level(), rand_level()), draw_gap(1'b0));
      send(mk_mix(rand_level(), rand_level()), draw_gap(1'b0));
      send(mk_item(OP_RESTART), draw_gap(1'b0));
      settle();

      // Mono, one output per second against 65536 source samples: one frame steps the
      // position to the last store entry. Switching to stereo then makes the right
      // channel read one past the end of the store, which reads as zero.
      write_setting(mk_setting(VOLUME_RESET, RATE_SCALE_RESET, RATE_W'(STORE_DEPTH),
                               RATE_W'(1), 2'd1, POS_W'(STORE_DEPTH), 1'b0));
      send(mk_mix(rand_level(), rand_level()), draw_gap(1'b0));
      send(mk_load(16'hffff, 16'h4000), draw_gap(1'b0));
      settle();
      write_setting(mk_setting(VOLUME_RESET, '0, RATE_W'(STORE_DEPTH), RATE_W'(1),
                               2'd2, POS_W'(STORE_DEPTH), 1'b0));
      send(mk_mix(rand_level(), rand_level()), draw_gap(1'b0));
      send(mk_mix(rand_level(), rand_level()), draw_gap(1'b0));

      // Random part. Each phase writes a fresh setting while the voice is idle, usually
      // rewinds the voice, and then plays a burst that is mostly mix frames with loads,
      // restarts and the odd unused op mixed in. Loads mostly land in the played span.
      // Ignored ops are not counted.
      pressure_go = 1'b1;
      issued      = 0;
      while (issued < ITEM_TARGET) begin
         settle();
         write_setting(random_setting());
         req_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) != 0) begin
            send(mk_item(OP_RESTART), draw_gap(req_calm));
            issued++;
         end
         burst = $urandom_range(10, 60);
         for (int n = 0; n < burst; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
               item = mk_mix(rand_level(), rand_level());
            end else if (pick < 84) begin
               item = mk_load(16'($urandom_range(0, PLAY_SPAN)), 16'($urandom));
            end else if (pick < 88) begin
               item = mk_load(16'($urandom), 16'($urandom));
            end else if (pick < 96) begin
               item = mk_item(OP_RESTART);
            end else begin
               item = mk_item(OP_UNUSED);
            end
            send(item, draw_gap(req_calm));
            if (item.op != OP_UNUSED) begin
               issued++;
            end
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("resampling_voice_mixer_tb passed");
      end else begin
         $display("resampling_voice_mixer_tb failed");
      end
      $finish;
   end

endmodule

// File: resampling_voice_mixer.f
+incdir+src
src/rvm_pkg.sv
src/rvm_ram.sv
src/rvm_ctrl.sv
src/rvm_datapath.sv
src/resampling_voice_mixer.sv
src/rvm_checker.sv
verif/resampling_voice_mixer_checker.sv
verif/resampling_voice_mixer_tb.sv
